### hw/rtl/tss_pkg.sv
package tss_pkg;

    localparam int SIG_W       = 2;
    localparam int NUM_W       = 3;
    localparam int TIME_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int GREEN_SLOTS = 4;
    localparam int MAX_SIGNALS = 4;
    localparam int COUNT_WIDTH = 8;

    localparam logic [TIME_W-1:0] RST_GREEN_0  = 8'd2;
    localparam logic [TIME_W-1:0] RST_GREEN_1  = 8'd3;
    localparam logic [TIME_W-1:0] RST_GREEN_2  = 8'd1;
    localparam logic [TIME_W-1:0] RST_GREEN_3  = 8'd2;
    localparam logic [TIME_W-1:0] RST_YELLOW   = 8'd5;
    localparam logic [TIME_W-1:0] RST_ALL_RED  = 8'd2;
    localparam logic [NUM_W-1:0]  RST_NUM_SIGS = 3'd4;

    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        PH_GREEN  = 2'd0,
        PH_YELLOW = 2'd1,
        PH_ALLRED = 2'd2
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GREEN_0     = 3'd0,
        CFG_GREEN_1     = 3'd1,
        CFG_GREEN_2     = 3'd2,
        CFG_GREEN_3     = 3'd3,
        CFG_YELLOW      = 3'd4,
        CFG_ALL_RED     = 3'd5,
        CFG_NUM_SIGNALS = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [GREEN_SLOTS-1:0][TIME_W-1:0] green_time;
        logic [TIME_W-1:0]                  yellow_time;
        logic [TIME_W-1:0]                  all_red_time;
        logic [NUM_W-1:0]                   sig_count;  // effective, 1..MAX_SIGNALS
    } t_cfg;

endpackage

### hw/rtl/traffic_signal_sequencer.sv
// Junction signal sequencer with emergency preemption.
// Input channel (i_in_valid / o_in_ready) carries one beat per tick or
// request: i_mode low is a time tick, i_mode high latches i_emergency_index
// as the signal to serve, if it is in the rotation, once a green is cut.
// Output channel (o_out_valid / i_out_ready) carries one beat per input
// beat: active signal, phase, ticks remaining and the pending flag, all as
// they stand after that input.
// A taken beat is held in the input register until the state can advance.
// Throughput: one beat per cycle while results are taken; the sequencer
// state update is a single compare, decrement and index wrap between the
// input register and the state registers, also the result register.
// When the receiver stalls, the result holds and one more input beat is
// taken into the input register; then o_in_ready drops until the result
// is taken.
// Reset: signal 0 in green with its reset green length, nothing pending,
// all but r_mode and r_idx reset. The write port (i_cfg_we) is taken
// at any edge and should only be used while no beats are in flight.
module traffic_signal_sequencer #(
    parameter int COUNT_WIDTH = tss_pkg::COUNT_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tss_pkg::TIME_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic [tss_pkg::SIG_W-1:0]     i_emergency_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tss_pkg::SIG_W-1:0]     o_active_signal,
    output logic [1:0]                    o_phase,
    output logic [tss_pkg::TIME_W-1:0]    o_remaining,
    output logic                          o_request_pending
);

    tss_pkg::t_cfg             w_cfg;
    logic                      r_in_valid;
    logic                      r_mode;
    logic [tss_pkg::SIG_W-1:0] r_idx;
    logic                      r_out_valid;
    logic                      w_advance;
    logic                      w_fire;

    tss_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign w_advance  = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_advance;
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_mode <= i_mode;
            r_idx  <= i_emergency_index;
        end
    end

    tss_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (w_fire),
        .i_mode            (r_mode),
        .i_idx             (r_idx),
        .i_cfg             (w_cfg),
        .o_active_signal   (o_active_signal),
        .o_phase           (o_phase),
        .o_remaining       (o_remaining),
        .o_request_pending (o_request_pending)
    );

    assign o_out_valid = r_out_valid;

endmodule

### hw/rtl/tss_cfg_regs.sv
module tss_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tss_pkg::TIME_W-1:0]    i_cfg_data,
    output tss_pkg::t_cfg                 o_cfg
);

    logic [tss_pkg::GREEN_SLOTS-1:0][tss_pkg::TIME_W-1:0] r_green;
    logic [tss_pkg::TIME_W-1:0] r_yellow;
    logic [tss_pkg::TIME_W-1:0] r_all_red;
    logic [tss_pkg::NUM_W-1:0]  r_num;
    logic [tss_pkg::NUM_W-1:0]  w_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_green[0] <= tss_pkg::RST_GREEN_0;
            r_green[1] <= tss_pkg::RST_GREEN_1;
            r_green[2] <= tss_pkg::RST_GREEN_2;
            r_green[3] <= tss_pkg::RST_GREEN_3;
            r_yellow   <= tss_pkg::RST_YELLOW;
            r_all_red  <= tss_pkg::RST_ALL_RED;
            r_num      <= tss_pkg::RST_NUM_SIGS;
        end else if (i_cfg_we) begin
            case (tss_pkg::t_cfg_idx'(i_cfg_index))
                tss_pkg::CFG_GREEN_0:     r_green[0] <= i_cfg_data;
                tss_pkg::CFG_GREEN_1:     r_green[1] <= i_cfg_data;
                tss_pkg::CFG_GREEN_2:     r_green[2] <= i_cfg_data;
                tss_pkg::CFG_GREEN_3:     r_green[3] <= i_cfg_data;
                tss_pkg::CFG_YELLOW:      r_yellow   <= i_cfg_data;
                tss_pkg::CFG_ALL_RED:     r_all_red  <= i_cfg_data;
                tss_pkg::CFG_NUM_SIGNALS: r_num      <= i_cfg_data[tss_pkg::NUM_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, large values clamp to the hardware limit
    always_comb begin
        if (r_num == '0) begin
            w_count = tss_pkg::NUM_W'(1);
        end else if (r_num > tss_pkg::NUM_W'(tss_pkg::MAX_SIGNALS)) begin
            w_count = tss_pkg::NUM_W'(tss_pkg::MAX_SIGNALS);
        end else begin
            w_count = r_num;
        end
    end

    assign o_cfg.green_time   = r_green;
    assign o_cfg.yellow_time  = r_yellow;
    assign o_cfg.all_red_time = r_all_red;
    assign o_cfg.sig_count    = w_count;

endmodule

### hw/rtl/tss_core.sv
module tss_core #(
    parameter int COUNT_WIDTH = tss_pkg::COUNT_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic                       i_mode,
    input  logic [tss_pkg::SIG_W-1:0]  i_idx,
    input  tss_pkg::t_cfg              i_cfg,
    output logic [tss_pkg::SIG_W-1:0]  o_active_signal,
    output logic [1:0]                 o_phase,
    output logic [tss_pkg::TIME_W-1:0] o_remaining,
    output logic                       o_request_pending
);

    localparam int EXT_W = COUNT_WIDTH + tss_pkg::TIME_W;

    tss_pkg::t_phase            r_phase, n_phase;
    logic [tss_pkg::SIG_W-1:0]  r_cur, n_cur;
    logic [COUNT_WIDTH-1:0]     r_count, n_count;
    logic                       r_pend, n_pend;
    logic [tss_pkg::SIG_W-1:0]  r_pend_sig, n_pend_sig;
    logic                       r_cut, n_cut;

    logic [tss_pkg::NUM_W-1:0]  w_next_wide;
    logic [tss_pkg::SIG_W-1:0]  w_next_sig;
    logic [tss_pkg::SIG_W-1:0]  w_green_sig;
    logic [COUNT_WIDTH-1:0]     w_green_len;
    logic [COUNT_WIDTH-1:0]     w_yellow_len;
    logic [COUNT_WIDTH-1:0]     w_all_red_len;
    logic [EXT_W-1:0]           w_green_ext;
    logic [EXT_W-1:0]           w_yellow_ext;
    logic [EXT_W-1:0]           w_all_red_ext;
    logic [EXT_W-1:0]           w_rst_ext;
    logic [EXT_W-1:0]           w_rem_ext;

    // phase lengths fitted to the counter width
    assign w_green_ext   = {COUNT_WIDTH'(0), i_cfg.green_time[w_green_sig]};
    assign w_yellow_ext  = {COUNT_WIDTH'(0), i_cfg.yellow_time};
    assign w_all_red_ext = {COUNT_WIDTH'(0), i_cfg.all_red_time};
    assign w_rst_ext     = {COUNT_WIDTH'(0), tss_pkg::RST_GREEN_0};
    assign w_green_len   = w_green_ext[COUNT_WIDTH-1:0];
    assign w_yellow_len  = w_yellow_ext[COUNT_WIDTH-1:0];
    assign w_all_red_len = w_all_red_ext[COUNT_WIDTH-1:0];

    always_comb begin
        w_next_wide = {1'b0, r_cur} + tss_pkg::NUM_W'(1);
        if (w_next_wide >= i_cfg.sig_count) begin
            w_next_sig = '0;
        end else begin
            w_next_sig = w_next_wide[tss_pkg::SIG_W-1:0];
        end
        w_green_sig = (r_cut && r_pend) ? r_pend_sig : w_next_sig;
    end

    always_comb begin
        n_phase    = r_phase;
        n_cur      = r_cur;
        n_count    = r_count;
        n_pend     = r_pend;
        n_pend_sig = r_pend_sig;
        n_cut      = r_cut;
        if (i_fire) begin
            if (i_mode == tss_pkg::MODE_REQUEST) begin
                if ({1'b0, i_idx} < i_cfg.sig_count) begin
                    n_pend     = 1'b1;
                    n_pend_sig = i_idx;
                end
            end else if (r_phase == tss_pkg::PH_GREEN && r_pend) begin
                // preemption cuts green short
                n_cut   = 1'b1;
                n_phase = tss_pkg::PH_YELLOW;
                n_count = w_yellow_len;
            end else if (r_count > COUNT_WIDTH'(1)) begin
                n_count = r_count - COUNT_WIDTH'(1);
            end else begin
                case (r_phase)
                    tss_pkg::PH_GREEN: begin
                        n_phase = tss_pkg::PH_YELLOW;
                        n_count = w_yellow_len;
                    end
                    tss_pkg::PH_YELLOW: begin
                        n_phase = tss_pkg::PH_ALLRED;
                        n_count = w_all_red_len;
                    end
                    default: begin
                        if (r_cut && r_pend) begin
                            n_pend = 1'b0;
                        end
                        n_cut   = 1'b0;
                        n_cur   = w_green_sig;
                        n_phase = tss_pkg::PH_GREEN;
                        n_count = w_green_len;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= tss_pkg::PH_GREEN;
            r_cur      <= '0;
            r_count    <= w_rst_ext[COUNT_WIDTH-1:0];
            r_pend     <= 1'b0;
            r_pend_sig <= '0;
            r_cut      <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_cur      <= n_cur;
            r_count    <= n_count;
            r_pend     <= n_pend;
            r_pend_sig <= n_pend_sig;
            r_cut      <= n_cut;
        end
    end

    assign w_rem_ext = {tss_pkg::TIME_W'(0), r_count};

    always_comb begin
        o_active_signal   = r_cur;
        o_phase           = r_phase;
        o_remaining       = w_rem_ext[tss_pkg::TIME_W-1:0];
        o_request_pending = r_pend;
    end

endmodule

### tb/traffic_signal_sequencer_tb.sv
`timescale 1ns / 1ps

module traffic_signal_sequencer_tb;
    import tss_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    typedef struct packed {
        logic                 mode;
        logic [SIG_W-1:0]     idx;
    } t_sig_beat;

    typedef struct packed {
        logic [SIG_W-1:0]     sig;
        t_phase               ph;
        logic [TIME_W-1:0]    rem;
        logic                 pend;
    } t_light_state;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [TIME_W-1:0]    i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_mode = MODE_TICK;
    logic [SIG_W-1:0]     i_emergency_index = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [SIG_W-1:0]     o_active_signal;
    logic [1:0]           o_phase;
    logic [TIME_W-1:0]    o_remaining;
    logic                 o_request_pending;

    t_sig_beat    queued_beats[$];
    t_light_state light_expected[$];

    // sequencer shadow state and register copy
    logic [TIME_W-1:0] green_len [GREEN_SLOTS];
    logic [TIME_W-1:0] yellow_len;
    logic [TIME_W-1:0] red_len;
    logic [NUM_W-1:0]  num_cfg;
    logic [SIG_W-1:0]  cur_sig;
    t_phase            cur_phase;
    logic [TIME_W-1:0] cur_count;
    logic              req_pending;
    logic [SIG_W-1:0]  req_sig;
    logic              green_cut;

    int unsigned mismatches = 0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_req = 0;
    int unsigned hold_seen = 0;
    bit          calm = 1'b0;

    traffic_signal_sequencer u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_emergency_index (i_emergency_index),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_active_signal   (o_active_signal),
        .o_phase           (o_phase),
        .o_remaining       (o_remaining),
        .o_request_pending (o_request_pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int rotation_len();
        int n;
        n = num_cfg;
        if (n == 0) n = 1;
        if (n > MAX_SIGNALS) n = MAX_SIGNALS;
        if (n > GREEN_SLOTS) n = GREEN_SLOTS;
        return n;
    endfunction

    task automatic start_green(input logic [SIG_W-1:0] s);
        cur_sig   = s;
        cur_phase = PH_GREEN;
        cur_count = green_len[s];
    endtask

    task automatic tick_sequencer();
        int nxt;
        if (cur_phase == PH_GREEN && req_pending) begin
            // pending request cuts green short
            green_cut = 1'b1;
            cur_phase = PH_YELLOW;
            cur_count = yellow_len;
        end else if (cur_count > 1) begin
            cur_count = cur_count - 1'b1;
        end else begin
            case (cur_phase)
                PH_GREEN: begin
                    cur_phase = PH_YELLOW;
                    cur_count = yellow_len;
                end
                PH_YELLOW: begin
                    cur_phase = PH_ALLRED;
                    cur_count = red_len;
                end
                default: begin
                    if (green_cut && req_pending) begin
                        req_pending = 1'b0;
                        green_cut   = 1'b0;
                        start_green(req_sig);
                    end else begin
                        green_cut = 1'b0;
                        nxt = cur_sig + 1;
                        if (nxt >= rotation_len()) nxt = 0;
                        start_green(nxt[SIG_W-1:0]);
                    end
                end
            endcase
        end
    endtask

    task automatic predict_beat(input logic mode, input logic [SIG_W-1:0] idx);
        if (mode == MODE_REQUEST) begin
            if (idx < rotation_len()) begin
                req_pending = 1'b1;
                req_sig     = idx;
            end
        end else begin
            tick_sequencer();
        end
        light_expected.push_back('{cur_sig, cur_phase, cur_count, req_pending});
    endtask

    task automatic reset_predictor();
        green_len[0] = RST_GREEN_0;
        green_len[1] = RST_GREEN_1;
        green_len[2] = RST_GREEN_2;
        green_len[3] = RST_GREEN_3;
        yellow_len   = RST_YELLOW;
        red_len      = RST_ALL_RED;
        num_cfg      = RST_NUM_SIGS;
        req_pending  = 1'b0;
        req_sig      = '0;
        green_cut    = 1'b0;
        start_green('0);
    endtask

    task automatic set_reg(input t_cfg_idx idx, input logic [TIME_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_GREEN_0, CFG_GREEN_1, CFG_GREEN_2, CFG_GREEN_3: green_len[idx] = val;
            CFG_YELLOW:      yellow_len = val;
            CFG_ALL_RED:     red_len    = val;
            CFG_NUM_SIGNALS: num_cfg    = val[NUM_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic program_all(input logic [TIME_W-1:0] g0, input logic [TIME_W-1:0] g1,
                               input logic [TIME_W-1:0] g2, input logic [TIME_W-1:0] g3,
                               input logic [TIME_W-1:0] y, input logic [TIME_W-1:0] r,
                               input logic [TIME_W-1:0] n);
        set_reg(CFG_GREEN_0, g0);
        set_reg(CFG_GREEN_1, g1);
        set_reg(CFG_GREEN_2, g2);
        set_reg(CFG_GREEN_3, g3);
        set_reg(CFG_YELLOW, y);
        set_reg(CFG_ALL_RED, r);
        set_reg(CFG_NUM_SIGNALS, n);
    endtask

    function automatic logic [TIME_W-1:0] rand_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 10) return 8'd255;
        if (r < 20) return TIME_W'($urandom_range(20, 7));
        return TIME_W'($urandom_range(6, 1));
    endfunction

    function automatic logic [TIME_W-1:0] rand_num();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 20) return TIME_W'($urandom_range(7, 5));
        return TIME_W'($urandom_range(4, 1));
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    task automatic push_beat(input logic mode, input logic [SIG_W-1:0] idx);
        queued_beats.push_back('{mode, idx});
    endtask

    // sampled at the falling edge so the clocked processes have settled
    task automatic wait_drained();
        do @(negedge i_clk);
        while (queued_beats.size() != 0 || i_in_valid || light_expected.size() != 0);
    endtask

    task automatic run_random(input int unsigned count);
        @(negedge i_clk);
        repeat (count) begin
            if ($urandom_range(99) < 15) push_beat(MODE_REQUEST, SIG_W'($urandom_range(3)));
            else push_beat(MODE_TICK, SIG_W'($urandom_range(3)));
        end
        wait_drained();
    endtask

    // sender
    always @(posedge i_clk) begin
        t_sig_beat nxt_beat;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) predict_beat(i_mode, i_emergency_index);
            if (!(i_in_valid && !o_in_ready)) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (queued_beats.size() != 0) begin
                    nxt_beat = queued_beats.pop_front();
                    i_in_valid        <= 1'b1;
                    i_mode            <= nxt_beat.mode;
                    i_emergency_index <= nxt_beat.idx;
                    send_gap = pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_light_state want;
        int unsigned  r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (light_expected.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat sig %0d phase %0d rem %0d pend %0b",
                             $time, o_active_signal, o_phase, o_remaining, o_request_pending);
                end else begin
                    want = light_expected.pop_front();
                    if (o_active_signal !== want.sig) begin
                        mismatches++;
                        $display("%0t: active_signal expected %0d, got %0d",
                                 $time, want.sig, o_active_signal);
                    end
                    if (o_phase !== want.ph) begin
                        mismatches++;
                        $display("%0t: phase expected %0d, got %0d", $time, want.ph, o_phase);
                    end
                    if (o_remaining !== want.rem) begin
                        mismatches++;
                        $display("%0t: remaining expected %0d, got %0d",
                                 $time, want.rem, o_remaining);
                    end
                    if (o_request_pending !== want.pend) begin
                        mismatches++;
                        $display("%0t: request_pending expected %0b, got %0b",
                                 $time, want.pend, o_request_pending);
                    end
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen  = hold_req;
                recv_stall = 80;
            end
            if (recv_stall != 0) begin
                recv_stall--;
                i_out_ready <= 1'b0;
            end else if (calm) begin
                i_out_ready <= 1'b1;
            end else begin
                r = $urandom_range(99);
                if (r < 75) begin
                    i_out_ready <= 1'b1;
                end else begin
                    i_out_ready <= 1'b0;
                    recv_stall = (r < 97) ? $urandom_range(2, 0) : $urandom_range(30, 10);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("traffic_signal_sequencer: mismatch");
            $finish;
        end
    end

    initial begin
        reset_predictor();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset lengths: request during yellow of an uncut green, then a cut
        // green with the request overwritten, ending on signal 3
        @(negedge i_clk);
        repeat (2) push_beat(MODE_TICK, 2'd0);
        push_beat(MODE_REQUEST, 2'd3);
        repeat (7) push_beat(MODE_TICK, 2'd1);
        push_beat(MODE_REQUEST, 2'd1);
        push_beat(MODE_REQUEST, 2'd3);
        repeat (8) push_beat(MODE_TICK, 2'd2);
        wait_drained();

        // rotation shrunk under the active signal, zero lengths, ignored requests
        set_reg(CFG_NUM_SIGNALS, 8'd2);
        set_reg(CFG_GREEN_0, 8'd0);
        set_reg(CFG_YELLOW, 8'd1);
        set_reg(CFG_ALL_RED, 8'd0);
        @(negedge i_clk);
        push_beat(MODE_REQUEST, 2'd3);
        push_beat(MODE_REQUEST, 2'd2);
        repeat (5) push_beat(MODE_TICK, 2'd3);
        push_beat(MODE_REQUEST, 2'd1);
        repeat (4) push_beat(MODE_TICK, 2'd0);
        wait_drained();

        program_all(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd7);
        run_random(300);
        program_all(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd0);
        run_random(100);

        for (int k = 0; k < 6; k++) begin
            program_all(rand_len(), rand_len(), rand_len(), rand_len(),
                        rand_len(), rand_len(), rand_num());
            @(negedge i_clk);
            calm = (k == 3);
            // long receiver hold while the sender keeps offering beats
            if (k == 0) hold_req++;
            run_random(200);
        end
        calm = 1'b0;

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && light_expected.size() == 0)
            $display("traffic_signal_sequencer: match");
        else
            $display("traffic_signal_sequencer: mismatch");
        $finish;
    end

endmodule

### traffic_signal_sequencer.f
hw/rtl/tss_pkg.sv
hw/rtl/tss_cfg_regs.sv
hw/rtl/tss_core.sv
hw/rtl/traffic_signal_sequencer.sv
tb/traffic_signal_sequencer_tb.sv
